// ----- hdl/hspoll_pkg.sv -----
// ============================================================================
// hspoll_pkg: shared codes and helpers for the sensor poller
// Bus request codes, bus event codes, sensor command words, register
// indexes, reset values and the fixed-point conversion helper.
// ============================================================================
`default_nettype none

package hspoll_pkg;

  // Bus request codes shown on bus_request
  localparam logic [2:0] REQ_NONE  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_FETCH = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_ABORT = 3'd4;

  // Bus event codes
  localparam logic [1:0] EV_STARTED = 2'd0;
  localparam logic [1:0] EV_TXDONE  = 2'd1;
  localparam logic [1:0] EV_RXDONE  = 2'd2;
  localparam logic [1:0] EV_ABORTED = 2'd3;

  // Sensor command words, MSB first on the bus
  localparam logic [15:0] CMD_START_WORD = 16'h2130;
  localparam logic [15:0] CMD_FETCH_WORD = 16'hE000;

  // Config register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd1;

  // Config reset values
  localparam logic [15:0] PERIOD_RESET  = 16'd1000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // Conversion: temp = (17500*raw - 4500*65535) / 65535, humi = 10000*raw / 65535
  localparam logic [14:0] TEMP_GAIN   = 15'd17500;
  localparam logic [31:0] TEMP_OFFSET = 32'd294907500;
  localparam logic [13:0] HUMI_GAIN   = 14'd10000;

  localparam logic [15:0] SAT_MAX = 16'hFFFF;

  // Divide by 65535: x = 65536*q0 + lo = 65535*q0 + (q0 + lo).
  // Remainder q0 + lo stays below 2*65535, so one correction step is exact.
  function automatic logic [13:0] div65535(input logic [29:0] x);
    logic [13:0] q0;
    logic [16:0] r0;
    q0 = x[29:16];
    r0 = 17'(x[15:0]) + 17'(q0);
    return (r0 >= 17'd65535) ? (q0 + 14'd1) : q0;
  endfunction

  // Saturating increment of a 16-bit counter
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == SAT_MAX) ? v : (v + 16'd1);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/humidity_sensor_poll_fsm.sv -----
// ============================================================================
// humidity_sensor_poll_fsm: periodic poller for a temperature/humidity sensor
// Drives start, fetch, read and abort requests toward an I2C master and converts
// the raw readings to hundredths of a degree and of a percent.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one word per tick (cmd = 0) or per bus
//   event to latch (cmd = 1). Every input word yields exactly one output word.
//   Output channel (out_valid/out_ready): bus request, command word, latest
//   readings, reading flags and the failure count.
//   Config channel (cfg_valid/cfg_ready): always ready; index 0 is the
//   period, index 1 the timeout, higher indexes are dropped. Write only
//   while no word is in flight.
//   Pipeline: two register stages; an accepted word goes into the input
//   register, then into the result register, which drives the output.
//   Throughput: one word per cycle while the output is taken; the step logic between the two
//   registers is a single pass, with the conversion multipliers placed
//   ahead of the input register.
//   Stall: while the output word is not taken, the input register holds its
//   word and in_ready drops once it is full; nothing is dropped.
//   Reset: synchronous, clears both stages, the sequencer state, the
//   stored readings and the failure count; config returns to 1000 and 200.
// ============================================================================
`default_nettype none

module humidity_sensor_poll_fsm (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic [1:0]                          event_code,
  input  wire logic                                request_ok,
  input  wire logic [15:0]                         raw_temp,
  input  wire logic [15:0]                         raw_humi,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               bus_request,
  output logic [15:0]                              command_word,
  output logic signed [14:0]                       temp_centi,
  output logic [13:0]                              humi_centi,
  output logic                                     reading_valid,
  output logic                                     new_reading,
  output logic [15:0]                              failures,
  // config channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hspoll_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [15:0]                         cfg_data
);

  import hspoll_pkg::*;

  typedef enum logic [2:0] {
    PH_NEED_START = 3'd0,
    PH_START_WAIT = 3'd1,
    PH_IDLE       = 3'd2,
    PH_FETCH_WAIT = 3'd3,
    PH_RX_WAIT    = 3'd4
  } phase_t;

  // config registers
  logic [15:0] period_ticks;
  logic [15:0] timeout_ticks;

  // input register stage
  logic        a_valid;
  logic        a_cmd;
  logic [1:0]  a_ev;
  logic        a_ok;
  logic [30:0] a_temp_prod;
  logic [29:0] a_humi_prod;

  // sequencer state
  phase_t             phase, phase_next;
  logic [1:0]         event_latch, event_latch_next;
  logic [15:0]        step_elapsed, step_elapsed_next;
  logic [15:0]        period_elapsed, period_elapsed_next;
  logic [15:0]        fail_total, fail_total_next;
  logic               have_reading, have_reading_next;
  logic signed [14:0] temp_store, temp_store_next;
  logic [13:0]        humi_store, humi_store_next;

  // step outputs
  logic [2:0]  req;
  logic [15:0] word;
  logic        fresh;
  logic        do_fail;
  logic        do_issue;
  phase_t      issue_phase;
  logic [15:0] step_inc;
  logic [15:0] period_inc;
  logic        waiting;

  // conversion
  logic signed [31:0] t_diff;
  logic               t_neg;
  logic [31:0]        t_abs;
  logic [13:0]        t_quot;
  logic signed [14:0] conv_temp;
  logic [13:0]        conv_humi;

  logic advance;

  // handshakes
  assign cfg_ready = 1'b1;
  assign advance   = a_valid && (!out_valid || out_ready);
  assign in_ready  = !a_valid || !out_valid || out_ready;

  // fixed-point conversion from the registered products
  assign t_diff    = $signed({1'b0, a_temp_prod}) - $signed(TEMP_OFFSET);
  assign t_neg     = t_diff[31];
  assign t_abs     = t_neg ? (32'd0 - 32'(t_diff)) : 32'(t_diff);
  assign t_quot    = div65535(t_abs[29:0]);
  assign conv_temp = t_neg ? (15'sd0 - $signed({1'b0, t_quot})) : $signed({1'b0, t_quot});
  assign conv_humi = div65535(a_humi_prod);

  // one sequencer step per word
  always_comb begin
    phase_next          = phase;
    event_latch_next    = event_latch;
    step_elapsed_next   = step_elapsed;
    period_elapsed_next = period_elapsed;
    fail_total_next     = fail_total;
    have_reading_next   = have_reading;
    temp_store_next     = temp_store;
    humi_store_next     = humi_store;
    req                 = REQ_NONE;
    word                = 16'd0;
    fresh               = 1'b0;
    do_fail             = 1'b0;
    do_issue            = 1'b0;
    issue_phase         = PH_NEED_START;
    step_inc            = sat_inc16(step_elapsed);
    period_inc          = sat_inc16(period_elapsed);
    waiting             = (phase == PH_START_WAIT) || (phase == PH_FETCH_WAIT) ||
                          (phase == PH_RX_WAIT);

    if (a_cmd) begin
      event_latch_next = a_ev;
    end else begin
      step_elapsed_next   = step_inc;
      period_elapsed_next = period_inc;
      if (waiting && (step_inc >= timeout_ticks)) begin
        do_fail = 1'b1;
        req     = REQ_ABORT;
      end else begin
        case (phase)
          PH_NEED_START: begin
            if ((fail_total == 16'd0) || (period_inc >= period_ticks)) begin
              word        = CMD_START_WORD;
              req         = REQ_START;
              do_issue    = 1'b1;
              issue_phase = PH_START_WAIT;
            end
          end
          PH_START_WAIT: begin
            if (event_latch == EV_TXDONE) begin
              period_elapsed_next = 16'd0;
              phase_next          = PH_IDLE;
            end else if (event_latch == EV_ABORTED) begin
              do_fail = 1'b1;
              req     = REQ_ABORT;
            end
          end
          PH_IDLE: begin
            if (period_inc >= period_ticks) begin
              word        = CMD_FETCH_WORD;
              req         = REQ_FETCH;
              do_issue    = 1'b1;
              issue_phase = PH_FETCH_WAIT;
            end
          end
          PH_FETCH_WAIT: begin
            if (event_latch == EV_TXDONE) begin
              req         = REQ_READ;
              do_issue    = 1'b1;
              issue_phase = PH_RX_WAIT;
            end else if (event_latch == EV_ABORTED) begin
              do_fail = 1'b1;
              req     = REQ_ABORT;
            end
          end
          PH_RX_WAIT: begin
            if (event_latch == EV_RXDONE) begin
              temp_store_next     = conv_temp;
              humi_store_next     = conv_humi;
              have_reading_next   = 1'b1;
              fresh               = 1'b1;
              phase_next          = PH_IDLE;
              period_elapsed_next = 16'd0;
            end else if (event_latch == EV_ABORTED) begin
              do_fail = 1'b1;
              req     = REQ_ABORT;
            end
          end
          default: begin
            phase_next = PH_NEED_START;
          end
        endcase
      end

      // request goes out; a refused request is a failure without abort
      if (do_issue) begin
        event_latch_next = EV_STARTED;
        if (a_ok) begin
          step_elapsed_next = 16'd0;
          phase_next        = issue_phase;
        end else begin
          do_fail = 1'b1;
        end
      end

      if (do_fail) begin
        fail_total_next     = sat_inc16(fail_total);
        phase_next          = PH_NEED_START;
        period_elapsed_next = 16'd0;
      end
    end
  end

  // control state, config and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks   <= PERIOD_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
      a_valid        <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= PH_NEED_START;
      event_latch    <= EV_STARTED;
      step_elapsed   <= 16'd0;
      period_elapsed <= 16'd0;
      fail_total     <= 16'd0;
      have_reading   <= 1'b0;
      temp_store     <= 15'sd0;
      humi_store     <= 14'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PERIOD) begin
          period_ticks <= cfg_data;
        end else if (cfg_index == CFG_TIMEOUT) begin
          timeout_ticks <= cfg_data;
        end
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        phase          <= phase_next;
        event_latch    <= event_latch_next;
        step_elapsed   <= step_elapsed_next;
        period_elapsed <= period_elapsed_next;
        fail_total     <= fail_total_next;
        have_reading   <= have_reading_next;
        temp_store     <= temp_store_next;
        humi_store     <= humi_store_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input word register; products formed ahead of it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd       <= cmd;
      a_ev        <= event_code;
      a_ok        <= request_ok;
      a_temp_prod <= 31'(raw_temp) * 31'(TEMP_GAIN);
      a_humi_prod <= 30'(raw_humi) * 30'(HUMI_GAIN);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (advance) begin
      bus_request   <= req;
      command_word  <= word;
      temp_centi    <= temp_store_next;
      humi_centi    <= humi_store_next;
      reading_valid <= have_reading_next;
      new_reading   <= fresh;
      failures      <= fail_total_next;
    end
  end

  // a fresh reading always marks the readings valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid && new_reading |-> reading_valid)
    else $error("new reading without reading_valid");

  // command word only rides with start and fetch writes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (bus_request != REQ_START) && (bus_request != REQ_FETCH)
      |-> command_word == 16'd0)
    else $error("command word on a non-write request");

  // failure count never goes down
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fail_total >= $past(fail_total))
    else $error("failure count decreased");

  // a fresh reading only comes out of the rx wait phase
  assert property (@(posedge clk) disable iff (rst)
    advance && fresh |-> phase == PH_RX_WAIT && event_latch == EV_RXDONE)
    else $error("conversion outside rx wait");

endmodule

`default_nettype wire
